>>> hdl/ufljt_pkg.sv
package ufljt_pkg;

   localparam int SEQ_W   = 32;
   localparam int SEC_W   = 32;
   localparam int USEC_W  = 20;
   localparam int BYTES_W = 32;
   localparam int TIME_W  = 64;
   localparam int TOTAL_W = 64;
   localparam int PROD_W  = SEC_W + USEC_W;
   localparam int FRAC_W  = 8;
   localparam int SHIFT_W = 4;

   localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
   localparam logic [TIME_W-1:0] JITTER_DELTA_MAX = 64'h00FF_FFFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      CLASS_IN_ORDER = 2'd0,
      CLASS_GAP      = 2'd1,
      CLASS_LATE     = 2'd2,
      CLASS_IGNORED  = 2'd3
   } order_class_type;

   typedef struct packed {
      logic [SEQ_W-1:0]   sequence_bits;
      logic [BYTES_W-1:0] payload_bytes;
      logic [TIME_W-1:0]  arrival_time_us;
      logic [TIME_W-1:0]  send_time_us;
   } send_stage_type;

   typedef struct packed {
      logic               counted;
      order_class_type    order_class;
      logic [SEQ_W-1:0]   loss;
      logic [BYTES_W-1:0] payload_bytes;
      logic [TIME_W-1:0]  transit;
   } class_stage_type;

   typedef struct packed {
      logic               counted;
      order_class_type    order_class;
      logic [SEQ_W-1:0]   loss;
      logic [BYTES_W-1:0] payload_bytes;
      logic               jitter_update;
      logic [TIME_W-1:0]  scaled_delta;
   } delta_stage_type;

endpackage

>>> hdl/ufljt_req_if.sv
interface ufljt_req_if;
   import ufljt_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [SEQ_W-1:0]   sequence_req;
   logic        [SEC_W-1:0]   send_seconds;
   logic        [USEC_W-1:0]  send_microseconds;
   logic        [BYTES_W-1:0] payload_bytes;
   logic        [TIME_W-1:0]  arrival_time_us;

   modport source (
      output valid, sequence_req, send_seconds, send_microseconds, payload_bytes,
         arrival_time_us,
      input  ready
   );

   modport sink (
      input  valid, sequence_req, send_seconds, send_microseconds, payload_bytes,
         arrival_time_us,
      output ready
   );

endinterface

>>> hdl/ufljt_rsp_if.sv
interface ufljt_rsp_if;
   import ufljt_pkg::*;

   logic               valid;
   logic               ready;
   logic               counted;
   logic [1:0]         order_class;
   logic [TOTAL_W-1:0] packet_total;
   logic [TOTAL_W-1:0] byte_total;
   logic [TOTAL_W-1:0] lost_total;
   logic [TOTAL_W-1:0] late_total;
   logic [TOTAL_W-1:0] jitter_estimate;

   modport source (
      output valid, counted, order_class, packet_total, byte_total, lost_total,
         late_total, jitter_estimate,
      input  ready
   );

   modport sink (
      input  valid, counted, order_class, packet_total, byte_total, lost_total,
         late_total, jitter_estimate,
      output ready
   );

endinterface

>>> hdl/ufljt_send_time.sv
module ufljt_send_time (
   input  logic                     clock,
   input  logic                     reset,
   ufljt_req_if.sink                req_channel,
   output logic                     out_valid,
   output ufljt_pkg::send_stage_type out_data,
   input  logic                     out_ready
);
   import ufljt_pkg::*;

   logic                 in_valid_ff;
   logic [SEQ_W-1:0]     seq_ff;
   logic [SEC_W-1:0]     seconds_ff;
   logic [USEC_W-1:0]    micros_ff;
   logic [BYTES_W-1:0]   bytes_ff;
   logic [TIME_W-1:0]    arrival_ff;
   logic                 out_valid_ff;
   send_stage_type       out_data_ff;
   send_stage_type       out_data_in;
   logic [PROD_W-1:0]    send_product;
   logic                 take_out;

   assign take_out          = !out_valid_ff || out_ready;
   assign req_channel.ready = !in_valid_ff || take_out;

   // seconds times one million, then the microsecond part
   assign send_product = {{USEC_W{1'b0}}, seconds_ff} * {{SEC_W{1'b0}}, USEC_PER_SEC};

   always_comb begin
      out_data_in.sequence_bits   = seq_ff;
      out_data_in.payload_bytes   = bytes_ff;
      out_data_in.arrival_time_us = arrival_ff;
      out_data_in.send_time_us    = TIME_W'(send_product) + TIME_W'(micros_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_channel.ready) begin
            in_valid_ff <= req_channel.valid;
         end
         if (take_out) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_channel.valid && req_channel.ready) begin
         seq_ff     <= $unsigned(req_channel.sequence_req);
         seconds_ff <= req_channel.send_seconds;
         micros_ff  <= req_channel.send_microseconds;
         bytes_ff   <= req_channel.payload_bytes;
         arrival_ff <= req_channel.arrival_time_us;
      end
      if (take_out && in_valid_ff) begin
         out_data_ff <= out_data_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

>>> hdl/ufljt_classify.sv
module ufljt_classify (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  ufljt_pkg::send_stage_type  in_data,
   output logic                      in_ready,
   output logic                      out_valid,
   output ufljt_pkg::class_stage_type out_data,
   input  logic                      out_ready
);
   import ufljt_pkg::*;

   logic [SEQ_W-1:0] expected_ff;
   logic [SEQ_W-1:0] expected_in;
   logic             out_valid_ff;
   class_stage_type  out_data_ff;
   class_stage_type  out_data_in;
   logic             in_xfer;

   assign in_ready = !out_valid_ff || out_ready;
   assign in_xfer  = in_valid && in_ready;

   always_comb begin
      expected_in               = expected_ff;
      out_data_in.counted       = !in_data.sequence_bits[SEQ_W-1];
      out_data_in.order_class   = CLASS_IGNORED;
      out_data_in.loss          = '0;
      out_data_in.payload_bytes = in_data.payload_bytes;
      out_data_in.transit       = in_data.arrival_time_us - in_data.send_time_us;
      if (out_data_in.counted) begin
         priority if (in_data.sequence_bits == expected_ff) begin
            expected_in             = expected_ff + SEQ_W'(1);
            out_data_in.order_class = CLASS_IN_ORDER;
         end else if ($signed(in_data.sequence_bits) > $signed(expected_ff)) begin
            expected_in             = in_data.sequence_bits + SEQ_W'(1);
            out_data_in.order_class = CLASS_GAP;
            out_data_in.loss        = in_data.sequence_bits - expected_ff;
         end else begin
            out_data_in.order_class = CLASS_LATE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         expected_ff  <= '0;
      end else begin
         if (in_ready) begin
            out_valid_ff <= in_valid;
         end
         if (in_xfer) begin
            expected_ff <= expected_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_xfer) begin
         out_data_ff <= out_data_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

>>> hdl/ufljt_delta.sv
module ufljt_delta (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  ufljt_pkg::class_stage_type  in_data,
   output logic                       in_ready,
   output logic                       out_valid,
   output ufljt_pkg::delta_stage_type  out_data,
   input  logic                       out_ready
);
   import ufljt_pkg::*;

   logic              seen_ff;
   logic [TIME_W-1:0] prev_transit_ff;
   logic              out_valid_ff;
   delta_stage_type   out_data_ff;
   delta_stage_type   out_data_in;
   logic [TIME_W-1:0] delta_raw;
   logic [TIME_W-1:0] delta_mag;
   logic [TIME_W-1:0] delta_sat;
   logic              in_xfer;

   assign in_ready = !out_valid_ff || out_ready;
   assign in_xfer  = in_valid && in_ready;

   assign delta_raw = in_data.transit - prev_transit_ff;
   assign delta_mag = delta_raw[TIME_W-1] ? (TIME_W'(0) - delta_raw) : delta_raw;
   assign delta_sat = (delta_mag > JITTER_DELTA_MAX) ? JITTER_DELTA_MAX : delta_mag;

   always_comb begin
      out_data_in.counted       = in_data.counted;
      out_data_in.order_class   = in_data.order_class;
      out_data_in.loss          = in_data.loss;
      out_data_in.payload_bytes = in_data.payload_bytes;
      out_data_in.jitter_update = in_data.counted && seen_ff;
      out_data_in.scaled_delta  = {delta_sat[TIME_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff    <= 1'b0;
         seen_ff         <= 1'b0;
         prev_transit_ff <= '0;
      end else begin
         if (in_ready) begin
            out_valid_ff <= in_valid;
         end
         if (in_xfer && in_data.counted) begin
            seen_ff         <= 1'b1;
            prev_transit_ff <= in_data.transit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_xfer) begin
         out_data_ff <= out_data_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

>>> hdl/ufljt_accum.sv
module ufljt_accum (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  ufljt_pkg::delta_stage_type in_data,
   output logic                      in_ready,
   ufljt_rsp_if.source               rsp_channel
);
   import ufljt_pkg::*;

   logic                 out_valid_ff;
   logic                 counted_ff;
   order_class_type      class_ff;
   logic [TOTAL_W-1:0]   packets_ff;
   logic [TOTAL_W-1:0]   bytes_ff;
   logic [TOTAL_W-1:0]   lost_ff;
   logic [TOTAL_W-1:0]   late_ff;
   logic [TOTAL_W-1:0]   jitter_ff;
   logic [TOTAL_W-1:0]   jitter_in;
   logic signed [TOTAL_W:0] jitter_diff;
   logic signed [TOTAL_W:0] jitter_step;
   logic                 in_xfer;

   assign in_ready = !out_valid_ff || rsp_channel.ready;
   assign in_xfer  = in_valid && in_ready;

   // floor((q - j) / 16) as an arithmetic shift of the signed difference
   assign jitter_diff = $signed({1'b0, in_data.scaled_delta} - {1'b0, jitter_ff});
   assign jitter_step = jitter_diff >>> SHIFT_W;
   assign jitter_in   = jitter_ff + jitter_step[TOTAL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         packets_ff   <= '0;
         bytes_ff     <= '0;
         lost_ff      <= '0;
         late_ff      <= '0;
         jitter_ff    <= '0;
      end else begin
         if (in_ready) begin
            out_valid_ff <= in_valid;
         end
         if (in_xfer && in_data.counted) begin
            packets_ff <= packets_ff + TOTAL_W'(1);
            bytes_ff   <= bytes_ff + TOTAL_W'(in_data.payload_bytes);
            lost_ff    <= lost_ff + TOTAL_W'(in_data.loss);
            late_ff    <= late_ff + TOTAL_W'(in_data.order_class == CLASS_LATE);
         end
         if (in_xfer && in_data.jitter_update) begin
            jitter_ff <= jitter_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_xfer) begin
         counted_ff <= in_data.counted;
         class_ff   <= in_data.order_class;
      end
   end

   assign rsp_channel.valid           = out_valid_ff;
   assign rsp_channel.counted         = counted_ff;
   assign rsp_channel.order_class     = class_ff;
   assign rsp_channel.packet_total    = packets_ff;
   assign rsp_channel.byte_total      = bytes_ff;
   assign rsp_channel.lost_total      = lost_ff;
   assign rsp_channel.late_total      = late_ff;
   assign rsp_channel.jitter_estimate = jitter_ff;

endmodule

>>> hdl/udp_flow_loss_jitter_tracker_unit.sv
// udp flow loss and jitter tracker
// req_channel carries one received packet summary per transfer: sequence
// number, send timestamp, byte count and local arrival time in microseconds
// rsp_channel returns exactly one result per packet, in order: counted flag,
// order class and the running packet, byte, loss, late and jitter totals
// a negative sequence number gives an ignored result with totals unchanged
// five register stages: input, send time multiply, transit and sequence
// class, transit delta, then totals and jitter in the result register
// a request reaches rsp_channel through the input, send time, class, delta and result registers in order
// throughput: one packet per cycle while rsp_channel is ready; each stage holds one
// item and takes the next whenever its own output moves on or is empty
// a stalled rsp_channel holds the result; the stages behind it keep filling
// until all are full, then req_channel.ready drops
// reset (synchronous) clears all totals, the expected sequence, the transit
// history and the jitter estimate, and empties the pipeline
module udp_flow_loss_jitter_tracker_unit (
   input  logic         clock,
   input  logic         reset,
   ufljt_req_if.sink    req_channel,
   ufljt_rsp_if.source  rsp_channel
);
   import ufljt_pkg::*;

   logic            send_valid;
   logic            send_ready;
   send_stage_type  send_data;
   logic            class_valid;
   logic            class_ready;
   class_stage_type class_data;
   logic            delta_valid;
   logic            delta_ready;
   delta_stage_type delta_data;

   ufljt_send_time u_send_time (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_channel),
      .out_valid   (send_valid),
      .out_data    (send_data),
      .out_ready   (send_ready)
   );

   ufljt_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (send_valid),
      .in_data   (send_data),
      .in_ready  (send_ready),
      .out_valid (class_valid),
      .out_data  (class_data),
      .out_ready (class_ready)
   );

   ufljt_delta u_delta (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (class_valid),
      .in_data   (class_data),
      .in_ready  (class_ready),
      .out_valid (delta_valid),
      .out_data  (delta_data),
      .out_ready (delta_ready)
   );

   ufljt_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (delta_valid),
      .in_data     (delta_data),
      .in_ready    (delta_ready),
      .rsp_channel (rsp_channel)
   );

endmodule

>>> tb/sv/udp_flow_loss_jitter_tracker_unit_tb.sv
module udp_flow_loss_jitter_tracker_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ufljt_pkg::*;

   typedef struct packed {
      logic [SEQ_W-1:0]   seq;
      logic [SEC_W-1:0]   secs;
      logic [USEC_W-1:0]  usecs;
      logic [BYTES_W-1:0] bytes;
      logic [TIME_W-1:0]  arrival;
   } packet_summary_type;

   typedef struct packed {
      logic               counted;
      order_class_type    order_class;
      logic [TOTAL_W-1:0] packets;
      logic [TOTAL_W-1:0] bytes;
      logic [TOTAL_W-1:0] lost;
      logic [TOTAL_W-1:0] late;
      logic [TOTAL_W-1:0] jitter;
   } flow_report_type;

   typedef struct {
      packet_summary_type pkt;
      bit                 typed;
      flow_report_type    report;
   } directed_row_type;

   localparam logic [SEQ_W-1:0] SEQ_MAGNITUDE_MASK = 32'h7FFF_FFFF;
   localparam flow_report_type  NO_REPORT = '0;
   localparam int               RANDOM_PACKETS = 800;

   logic clock = 1'b0;
   logic reset;

   ufljt_req_if req_channel();
   ufljt_rsp_if rsp_channel();

   udp_flow_loss_jitter_tracker_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_channel),
      .rsp_channel (rsp_channel)
   );

   always #5 clock = ~clock;

   // flow tracker state
   logic [TOTAL_W-1:0]      rx_packets;
   logic [TOTAL_W-1:0]      rx_bytes;
   logic [TOTAL_W-1:0]      lost_packets;
   logic [TOTAL_W-1:0]      late_packets;
   logic [TOTAL_W-1:0]      jitter_q8;
   logic [TIME_W-1:0]       last_transit;
   logic signed [SEQ_W-1:0] next_seq;
   logic                    transit_valid;

   flow_report_type  expected_reports[$];
   directed_row_type directed_rows[$];
   int               mismatch_count = 0;
   int               checked_count = 0;
   int               burst_left = 0;
   int               class_seen[4] = '{0, 0, 0, 0};

   function automatic flow_report_type track_packet(packet_summary_type p);
      flow_report_type   r;
      logic [TIME_W-1:0] transit;
      logic [TIME_W-1:0] delta;
      logic [TIME_W-1:0] scaled;
      longint            seq_val;
      longint            next_val;
      r.counted = 1'b0;
      r.order_class = CLASS_IGNORED;
      if (!p.seq[SEQ_W-1]) begin
         transit = p.arrival - ({32'd0, p.secs} * 64'd1000000 + {44'd0, p.usecs});
         seq_val = longint'($signed(p.seq));
         next_val = longint'(next_seq);
         r.counted = 1'b1;
         rx_packets = rx_packets + 64'd1;
         rx_bytes = rx_bytes + {32'd0, p.bytes};
         if (seq_val == next_val) begin
            next_seq = next_seq + 32'sd1;
            r.order_class = CLASS_IN_ORDER;
         end else if (seq_val > next_val) begin
            lost_packets = lost_packets + 64'(seq_val - next_val);
            next_seq = $signed(p.seq + 32'd1);
            r.order_class = CLASS_GAP;
         end else begin
            late_packets = late_packets + 64'd1;
            r.order_class = CLASS_LATE;
         end
         if (transit_valid) begin
            delta = transit - last_transit;
            if (delta[TIME_W-1]) begin
               delta = -delta;
            end
            if (delta > JITTER_DELTA_MAX) begin
               delta = JITTER_DELTA_MAX;
            end
            scaled = delta << FRAC_W;
            if (scaled >= jitter_q8) begin
               jitter_q8 = jitter_q8 + ((scaled - jitter_q8) >> SHIFT_W);
            end else begin
               jitter_q8 = jitter_q8 - ((jitter_q8 - scaled + 64'd15) >> SHIFT_W);
            end
         end
         transit_valid = 1'b1;
         last_transit = transit;
      end
      r.packets = rx_packets;
      r.bytes = rx_bytes;
      r.lost = lost_packets;
      r.late = late_packets;
      r.jitter = jitter_q8;
      return r;
   endfunction

   task automatic send_packet(input packet_summary_type p, input bit typed,
                              input flow_report_type typed_report);
      int              gap;
      flow_report_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap > 0) begin
            req_channel.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_channel.valid             <= 1'b1;
      req_channel.sequence_req      <= p.seq;
      req_channel.send_seconds      <= p.secs;
      req_channel.send_microseconds <= p.usecs;
      req_channel.payload_bytes     <= p.bytes;
      req_channel.arrival_time_us   <= p.arrival;
      do @(posedge clock); while (!req_channel.ready);
      predicted = track_packet(p);
      class_seen[predicted.order_class]++;
      expected_reports.push_back(typed ? typed_report : predicted);
   endtask

   // result side: check each transfer, stall on a rotating pattern
   initial begin
      flow_report_type seen;
      flow_report_type want;
      logic [15:0]     stall_pattern;
      int              pattern_age;
      stall_pattern = 16'hFFFF;
      pattern_age = 0;
      rsp_channel.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_channel.valid && rsp_channel.ready) begin
            seen.counted     = rsp_channel.counted;
            seen.order_class = order_class_type'(rsp_channel.order_class);
            seen.packets     = rsp_channel.packet_total;
            seen.bytes       = rsp_channel.byte_total;
            seen.lost        = rsp_channel.lost_total;
            seen.late        = rsp_channel.late_total;
            seen.jitter      = rsp_channel.jitter_estimate;
            if (expected_reports.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: result with nothing expected", $time);
               end
            end else begin
               want = expected_reports.pop_front();
               checked_count++;
               if (seen.counted !== want.counted || seen.order_class !== want.order_class ||
                   seen.packets !== want.packets || seen.bytes !== want.bytes ||
                   seen.lost !== want.lost || seen.late !== want.late ||
                   seen.jitter !== want.jitter) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: expected cnt=%0d cls=%0d pkts=%0d bytes=%0d",
                              $time, want.counted, want.order_class, want.packets,
                              want.bytes);
                     $display("%0t: expected lost=%0d late=%0d jit=%0d",
                              $time, want.lost, want.late, want.jitter);
                     $display("%0t: actual   cnt=%0d cls=%0d pkts=%0d bytes=%0d",
                              $time, seen.counted, seen.order_class, seen.packets,
                              seen.bytes);
                     $display("%0t: actual   lost=%0d late=%0d jit=%0d",
                              $time, seen.lost, seen.late, seen.jitter);
                  end
               end
            end
         end
         if (pattern_age == 0) begin
            stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF :
                            (16'($urandom) | 16'h0001);
            pattern_age = $urandom_range(40, 300);
         end
         pattern_age--;
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
         rsp_channel.ready <= stall_pattern[0];
      end
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      packet_summary_type p;
      logic [SEQ_W-1:0]   gen_seq;
      logic [TIME_W-1:0]  send_clock;
      logic [TIME_W-1:0]  path_delay;
      logic [TIME_W-1:0]  whole_secs;
      int                 pick;

      reset <= 1'b1;
      req_channel.valid             <= 1'b0;
      req_channel.sequence_req      <= '0;
      req_channel.send_seconds      <= '0;
      req_channel.send_microseconds <= '0;
      req_channel.payload_bytes     <= '0;
      req_channel.arrival_time_us   <= '0;

      rx_packets    = '0;
      rx_bytes      = '0;
      lost_packets  = '0;
      late_packets  = '0;
      jitter_q8     = '0;
      last_transit  = '0;
      next_seq      = '0;
      transit_valid = 1'b0;

      // first packet, ignored packets, byte extremes, gap and late
      directed_rows.push_back('{'{32'd0, 32'd0, 20'd0, 32'd100, 64'd1000}, 1'b1,
         '{1'b1, CLASS_IN_ORDER, 64'd1, 64'd100, 64'd0, 64'd0, 64'd0}});
      directed_rows.push_back('{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hF_FFFF, 32'hFFFF_FFFF,
         64'hFFFF_FFFF_FFFF_FFFF}, 1'b1,
         '{1'b0, CLASS_IGNORED, 64'd1, 64'd100, 64'd0, 64'd0, 64'd0}});
      directed_rows.push_back('{'{32'h8000_0000, 32'd0, 20'd0, 32'd0, 64'd0}, 1'b1,
         '{1'b0, CLASS_IGNORED, 64'd1, 64'd100, 64'd0, 64'd0, 64'd0}});
      directed_rows.push_back('{'{32'd1, 32'd0, 20'd0, 32'hFFFF_FFFF, 64'd1000}, 1'b1,
         '{1'b1, CLASS_IN_ORDER, 64'd2, 64'h1_0000_0063, 64'd0, 64'd0, 64'd0}});
      directed_rows.push_back('{'{32'd5, 32'd0, 20'd0, 32'd0, 64'd1016}, 1'b1,
         '{1'b1, CLASS_GAP, 64'd3, 64'h1_0000_0063, 64'd3, 64'd0, 64'd256}});
      directed_rows.push_back('{'{32'd3, 32'd0, 20'd0, 32'd1, 64'd1016}, 1'b1,
         '{1'b1, CLASS_LATE, 64'd4, 64'h1_0000_0064, 64'd3, 64'd1, 64'd240}});
      // duplicate, send time extremes, out of range microseconds
      directed_rows.push_back('{'{32'd3, 32'hFFFF_FFFF, 20'd999999, 32'd1500,
         64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, NO_REPORT});
      directed_rows.push_back('{'{32'd6, 32'd0, 20'hF_FFFF, 32'd64, 64'd0}, 1'b0, NO_REPORT});
      directed_rows.push_back('{'{32'd7, 32'hFFFF_FFFF, 20'hF_FFFF, 32'd64, 64'd0}, 1'b0,
         NO_REPORT});
      // transit swings that hit the delta clamp and the sign boundary
      directed_rows.push_back('{'{32'd8, 32'd0, 20'd0, 32'd64, 64'h7FFF_FFFF_FFFF_FFFF}, 1'b0,
         NO_REPORT});
      directed_rows.push_back('{'{32'd9, 32'd0, 20'd0, 32'd64, 64'h8000_0000_0000_0000}, 1'b0,
         NO_REPORT});
      directed_rows.push_back('{'{32'd10, 32'd0, 20'd0, 32'd64, 64'd0}, 1'b0, NO_REPORT});
      // jitter decays from a large value
      directed_rows.push_back('{'{32'd11, 32'd0, 20'd0, 32'd64, 64'd0}, 1'b0, NO_REPORT});
      directed_rows.push_back('{'{32'd12, 32'd0, 20'd0, 32'd64, 64'd0}, 1'b0, NO_REPORT});
      // sequence number wrap
      directed_rows.push_back('{'{32'h7FFF_FFFF, 32'd0, 20'd0, 32'hFFFF_FFFF, 64'd5000}, 1'b0,
         NO_REPORT});
      directed_rows.push_back('{'{32'd0, 32'd0, 20'd0, 32'd10, 64'd5003}, 1'b0, NO_REPORT});
      directed_rows.push_back('{'{32'd1, 32'd0, 20'd0, 32'd10, 64'd4990}, 1'b0, NO_REPORT});
      directed_rows.push_back('{'{32'h7FFF_FFFF, 32'd0, 20'd0, 32'd10, 64'd5100}, 1'b0,
         NO_REPORT});
      directed_rows.push_back('{'{32'h7FFF_FFFE, 32'd0, 20'd0, 32'd10, 64'd5100}, 1'b0,
         NO_REPORT});
      directed_rows.push_back('{'{32'd0, 32'd1, 20'd0, 32'd10, 64'd1_005_200}, 1'b0, NO_REPORT});
      directed_rows.push_back('{'{32'd1, 32'd1, 20'd999999, 32'd10, 64'd2_005_200}, 1'b0,
         NO_REPORT});

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_packet(directed_rows[i].pkt, directed_rows[i].typed, directed_rows[i].report);
      end

      // mostly well-formed flows with loss and reordering, some noise
      gen_seq = 32'd2;
      send_clock = {32'd0, $urandom_range(0, 32'hFFFF_0000)} * 64'd1000000;
      path_delay = 64'($urandom_range(0, 50000));
      for (int n = 0; n < RANDOM_PACKETS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            p.seq = $urandom | 32'h8000_0000;
         end else if (pick < 74) begin
            p.seq = gen_seq;
            gen_seq = (gen_seq + 32'd1) & SEQ_MAGNITUDE_MASK;
         end else if (pick < 84) begin
            gen_seq = (gen_seq + $urandom_range(1, 20)) & SEQ_MAGNITUDE_MASK;
            p.seq = gen_seq;
            gen_seq = (gen_seq + 32'd1) & SEQ_MAGNITUDE_MASK;
         end else if (pick < 94) begin
            p.seq = (gen_seq - $urandom_range(1, 12)) & SEQ_MAGNITUDE_MASK;
         end else if (pick < 97) begin
            p.seq = SEQ_MAGNITUDE_MASK - $urandom_range(0, 3);
            gen_seq = (p.seq + 32'd1) & SEQ_MAGNITUDE_MASK;
         end else begin
            p.seq = $urandom & SEQ_MAGNITUDE_MASK;
            gen_seq = (p.seq + 32'd1) & SEQ_MAGNITUDE_MASK;
         end

         if ($urandom_range(0, 29) == 0) begin
            path_delay = 64'($urandom_range(0, 2_000_000));
         end
         send_clock = send_clock + $urandom_range(1, 3000);
         if ($urandom_range(0, 19) == 0) begin
            p.secs = $urandom;
            p.usecs = USEC_W'($urandom_range(0, 20'hF_FFFF));
            p.arrival = {$urandom, $urandom};
         end else begin
            whole_secs = send_clock / 64'd1000000;
            p.secs = whole_secs[SEC_W-1:0];
            p.usecs = USEC_W'(send_clock % 64'd1000000);
            p.arrival = send_clock + path_delay + $urandom_range(0, 400);
         end
         p.bytes = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 1500);
         send_packet(p, 1'b0, NO_REPORT);
      end

      req_channel.valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("%0d packet results checked: %0d in order, %0d gaps, %0d late, %0d ignored",
               checked_count, class_seen[CLASS_IN_ORDER], class_seen[CLASS_GAP],
               class_seen[CLASS_LATE], class_seen[CLASS_IGNORED]);
      $display("sequence wrap, transit clamp and jitter decay exercised; %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/ufljt_pkg.sv
hdl/ufljt_req_if.sv
hdl/ufljt_rsp_if.sv
hdl/ufljt_send_time.sv
hdl/ufljt_classify.sv
hdl/ufljt_delta.sv
hdl/ufljt_accum.sv
hdl/udp_flow_loss_jitter_tracker_unit.sv
tb/sv/udp_flow_loss_jitter_tracker_unit_tb.sv
